// ----- rtl/core/htsn_pkg.sv -----
// Shared widths, byte codes and sequence phase codes for the HTML strip text normalizer.
package htsn_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned COUNT_W = 2;

   // Byte codes seen or produced by the normalizer.
   localparam logic [BYTE_W-1:0] CH_LEAD     = 8'hE2;
   localparam logic [BYTE_W-1:0] CH_MID      = 8'h80;
   localparam logic [BYTE_W-1:0] CH_LDQUO    = 8'h9C;
   localparam logic [BYTE_W-1:0] CH_RDQUO    = 8'h9D;
   localparam logic [BYTE_W-1:0] CH_LSQUO    = 8'h98;
   localparam logic [BYTE_W-1:0] CH_RSQUO    = 8'h99;
   localparam logic [BYTE_W-1:0] CH_ENDASH   = 8'h93;
   localparam logic [BYTE_W-1:0] CH_EMDASH   = 8'h94;
   localparam logic [BYTE_W-1:0] CH_ELLIPSIS = 8'hA6;
   localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_TAG_OPEN = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_TAG_SHUT = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_BSLASH   = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_DQUOTE   = 8'h22;
   localparam logic [BYTE_W-1:0] CH_APOS     = 8'h27;
   localparam logic [BYTE_W-1:0] CH_DASH     = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_DOT      = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;

   // UTF-8 sequence tracking phases.
   localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PH_LEAD = 2'd1;
   localparam logic [PHASE_W-1:0] PH_MID  = 2'd2;
   localparam logic [PHASE_W-1:0] PH_SKIP = 2'd3;

   // Beats still owed for one item.
   localparam logic [COUNT_W-1:0] CNT_NONE  = 2'd0;
   localparam logic [COUNT_W-1:0] CNT_ONE   = 2'd1;
   localparam logic [COUNT_W-1:0] CNT_THREE = 2'd3;

endpackage

// ----- rtl/core/htsn_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
interface htsn_req_if;
   import htsn_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_value;
   logic              has_byte;
   logic              line_end;

   modport source (output valid, byte_value, has_byte, line_end, input ready);
   modport sink   (input valid, byte_value, has_byte, line_end, output ready);
endinterface

interface htsn_rsp_if;
   import htsn_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_valid;
   logic              out_line_end;
   logic              last_of_run;

   modport source (output valid, out_byte, out_valid, out_line_end, last_of_run, input ready);
   modport sink   (input valid, out_byte, out_valid, out_line_end, last_of_run, output ready);
endinterface

// ----- rtl/core/html_strip_ascii_text_normalizer_unit.sv -----
// Top level: strips HTML tags and folds UTF-8 punctuation to ASCII, one byte per beat.
// Results of a request beat are registered and appear on the response side in the cycle after it is taken.
// Throughput: one request beat per cycle while each gives at most one response beat and the response
// side is ready; an ellipsis gives three response beats and so holds the request side until the last one leaves.
// Reset: synchronous, active high; clears tag, sequence and escape state and the
// pending response count. Response payload registers are not reset.
module html_strip_ascii_text_normalizer_unit (
   input logic        clock,
   input logic        reset,
   htsn_req_if.sink   req_bus,
   htsn_rsp_if.source rsp_bus
);
   import htsn_pkg::*;

   // Normalizer state that carries from one beat to the next.
   logic               inside_tag_ff, inside_tag_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               escape_ff, escape_in;

   // Response holding register. The ellipsis gives three identical dots, so one
   // byte register plus a count of beats still owed covers every case.
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               valid_ff, valid_in;
   logic               eol_ff, eol_in;

   logic               req_fire;
   logic               rsp_fire;

   // Item results computed from the beat being taken.
   logic [COUNT_W-1:0] item_cnt;
   logic [BYTE_W-1:0]  item_byte;

   assign rsp_fire = rsp_bus.valid & rsp_bus.ready;

   // A new beat can enter when nothing is owed, or when the last owed beat
   // leaves in this same cycle. This keeps single-result items streaming.
   assign req_bus.ready = (cnt_ff == CNT_NONE) || ((cnt_ff == CNT_ONE) && rsp_bus.ready);
   assign req_fire      = req_bus.valid & req_bus.ready;

   // Tag stripping runs first; only bytes outside a tag reach the punctuation stage.
   always_comb begin
      logic [BYTE_W-1:0] b;
      b             = req_bus.byte_value;
      inside_tag_in = inside_tag_ff;
      phase_in      = phase_ff;
      escape_in     = escape_ff;
      item_cnt      = CNT_NONE;
      item_byte     = b;

      if (req_bus.has_byte) begin
         priority if (inside_tag_ff) begin
            if (b == CH_TAG_SHUT) begin
               inside_tag_in = 1'b0;
            end
         end else if (b == CH_TAG_OPEN) begin
            inside_tag_in = 1'b1;
         end else if (phase_ff == PH_LEAD) begin
            phase_in = (b == CH_MID) ? PH_MID : PH_SKIP;
         end else if (phase_ff == PH_SKIP) begin
            phase_in = PH_IDLE;
         end else if (phase_ff == PH_MID) begin
            phase_in = PH_IDLE;
            unique case (b)
               CH_LDQUO, CH_RDQUO: begin
                  item_cnt  = CNT_ONE;
                  item_byte = CH_DQUOTE;
               end
               CH_LSQUO, CH_RSQUO: begin
                  item_cnt  = CNT_ONE;
                  item_byte = CH_APOS;
               end
               CH_ENDASH, CH_EMDASH: begin
                  item_cnt  = CNT_ONE;
                  item_byte = CH_DASH;
               end
               CH_ELLIPSIS: begin
                  item_cnt  = CNT_THREE;
                  item_byte = CH_DOT;
               end
               default: begin
                  item_cnt = CNT_NONE;
               end
            endcase
         end else if (escape_ff) begin
            // An escaped byte passes raw, whatever its value.
            escape_in = 1'b0;
            item_cnt  = CNT_ONE;
         end else if (b == CH_LEAD) begin
            phase_in = PH_LEAD;
         end else if (b == CH_BSLASH) begin
            escape_in = 1'b1;
         end else if ((b >= CH_PRINT_LO) && (b <= CH_PRINT_HI)) begin
            item_cnt = CNT_ONE;
         end else begin
            // Any other byte outside the printable range is dropped.
            item_cnt = CNT_NONE;
         end
      end

      // A line end drops any half-seen sequence or escape; an open tag survives.
      if (req_bus.line_end) begin
         phase_in  = PH_IDLE;
         escape_in = 1'b0;
      end
   end

   // Load the response register on a new beat, otherwise count down the owed beats.
   always_comb begin
      cnt_in   = cnt_ff;
      byte_in  = byte_ff;
      valid_in = valid_ff;
      eol_in   = eol_ff;
      if (req_fire) begin
         eol_in = req_bus.line_end;
         if ((item_cnt == CNT_NONE) && req_bus.line_end) begin
            // A line end with no byte to show still gets a bare marker beat.
            cnt_in   = CNT_ONE;
            byte_in  = CH_NUL;
            valid_in = 1'b0;
         end else begin
            cnt_in   = item_cnt;
            byte_in  = item_byte;
            valid_in = 1'b1;
         end
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_tag_ff <= 1'b0;
         phase_ff      <= PH_IDLE;
         escape_ff     <= 1'b0;
         cnt_ff        <= CNT_NONE;
      end else begin
         cnt_ff <= cnt_in;
         if (req_fire) begin
            inside_tag_ff <= inside_tag_in;
            phase_ff      <= phase_in;
            escape_ff     <= escape_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      valid_ff <= valid_in;
      eol_ff   <= eol_in;
   end

   // The final owed beat carries the run and line end flags.
   assign rsp_bus.valid        = (cnt_ff != CNT_NONE);
   assign rsp_bus.out_byte     = byte_ff;
   assign rsp_bus.out_valid    = valid_ff;
   assign rsp_bus.last_of_run  = (cnt_ff == CNT_ONE);
   assign rsp_bus.out_line_end = eol_ff && (cnt_ff == CNT_ONE);

endmodule

// ----- verif/tb_html_strip_ascii_text_normalizer_unit.sv -----
// Self-checking testbench for the HTML tag strip and UTF-8 punctuation folding unit.
`timescale 1ns / 100ps

module tb_html_strip_ascii_text_normalizer_unit;
   import htsn_pkg::*;

   // Generous cycle budget: the slowest correct run stays well below this.
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned RANDOM_ITEMS  = 450;
   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam int unsigned REPORT_LINES  = 40;

   // One expected response beat.
   typedef struct {
      logic [BYTE_W-1:0] ch;
      logic              carries;
      logic              eol;
      logic              last;
   } norm_beat_type;

   // The scoreboard keeps its own copy of the tag, sequence and escape state,
   // turns every accepted request beat into the response beats it must cause,
   // and checks the response stream against them in order.
   class norm_scoreboard_type;
      logic              in_tag;
      logic [PHASE_W-1:0] phase;
      logic              esc;
      norm_beat_type     owed_beats[$];
      logic [BYTE_W-1:0] made[$];
      int unsigned       mismatches;

      function new();
         in_tag     = 1'b0;
         phase      = PH_IDLE;
         esc        = 1'b0;
         mismatches = 0;
      endfunction

      task report(input string msg);
         if (mismatches < REPORT_LINES)
            $display("ERROR at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      // Second stage: punctuation folding, escapes and the printable filter.
      // Only bytes that survived tag stripping come here.
      function void fold_byte(input logic [BYTE_W-1:0] b);
         case (phase)
            PH_LEAD: begin
               phase = (b == CH_MID) ? PH_MID : PH_SKIP;
            end
            PH_SKIP: begin
               phase = PH_IDLE;
            end
            PH_MID: begin
               phase = PH_IDLE;
               case (b)
                  CH_LDQUO, CH_RDQUO: made.push_back(CH_DQUOTE);
                  CH_LSQUO, CH_RSQUO: made.push_back(CH_APOS);
                  CH_ENDASH, CH_EMDASH: made.push_back(CH_DASH);
                  CH_ELLIPSIS: begin
                     repeat (3) made.push_back(CH_DOT);
                  end
                  default: ;
               endcase
            end
            default: begin
               // An escaped byte goes out raw, whatever it is, lead byte included.
               if (esc) begin
                  esc = 1'b0;
                  made.push_back(b);
               end else if (b == CH_LEAD) begin
                  phase = PH_LEAD;
               end else if (b == CH_BSLASH) begin
                  esc = 1'b1;
               end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
                  made.push_back(b);
               end
            end
         endcase
      endfunction

      function void note_request(input logic [BYTE_W-1:0] b, input logic has,
                                 input logic eol);
         norm_beat_type nb;
         int            n;
         made.delete();
         if (has) begin
            // Tag stripping runs first, so '<' opens a tag even after a backslash.
            if (in_tag) begin
               if (b == CH_TAG_SHUT)
                  in_tag = 1'b0;
            end else if (b == CH_TAG_OPEN) begin
               in_tag = 1'b1;
            end else begin
               fold_byte(b);
            end
         end
         // A line end drops a half-seen sequence or escape but keeps an open tag.
         if (eol) begin
            phase = PH_IDLE;
            esc   = 1'b0;
         end
         n = made.size();
         for (int k = 0; k < n; k++) begin
            nb.ch      = made[k];
            nb.carries = 1'b1;
            nb.last    = (k == n - 1);
            nb.eol     = nb.last && eol;
            owed_beats.push_back(nb);
         end
         // A line end that yields no byte still gives one bare marker beat.
         if (n == 0 && eol) begin
            nb.ch      = CH_NUL;
            nb.carries = 1'b0;
            nb.eol     = 1'b1;
            nb.last    = 1'b1;
            owed_beats.push_back(nb);
         end
      endfunction

      task check_response(input logic [BYTE_W-1:0] ch, input logic carries,
                          input logic eol, input logic last);
         norm_beat_type want;
         if (owed_beats.size() == 0) begin
            report($sformatf("response beat %02h with nothing expected", ch));
         end else begin
            want = owed_beats.pop_front();
            if (ch !== want.ch)
               report($sformatf("out_byte %02h, expected %02h", ch, want.ch));
            if (carries !== want.carries)
               report($sformatf("out_valid %b, expected %b", carries, want.carries));
            if (eol !== want.eol)
               report($sformatf("out_line_end %b, expected %b", eol, want.eol));
            if (last !== want.last)
               report($sformatf("last_of_run %b, expected %b", last, want.last));
         end
      endtask

      function int unsigned pending();
         return owed_beats.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   htsn_req_if req_bus ();
   htsn_rsp_if rsp_bus ();

   html_strip_ascii_text_normalizer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   norm_scoreboard_type board = new();

   // While quiet is set, neither side inserts gaps, so back-to-back beats and
   // ellipsis back-pressure get exercised without any idling in between.
   logic        quiet;
   int unsigned cycle_count = 0;
   int unsigned hold_left   = 0;
   int unsigned random_sent;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(2, 1);
      if (r < 97)
         return $urandom_range(6, 3);
      return $urandom_range(30, 10);
   endfunction

   // Offers one request beat after a random gap and holds it until it is taken.
   // The predictor is updated at the edge where the beat is accepted.
   task automatic send_beat(input logic [BYTE_W-1:0] b, input logic has,
                            input logic eol);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.byte_value <= b;
      req_bus.has_byte   <= has;
      req_bus.line_end   <= eol;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(b, has, eol);
   endtask

   // One byte of the random part. Line ends fall at random, so some sequences
   // get cut short; now and then an empty item or a bare line end slips in.
   task automatic put(input logic [BYTE_W-1:0] b);
      logic eol_only;
      if ($urandom_range(99) < 4) begin
         eol_only = ($urandom_range(2) != 0);
         send_beat(8'($urandom_range(255)), 1'b0, eol_only);
         if (eol_only)
            random_sent++;
      end
      send_beat(b, 1'b1, $urandom_range(99) < 7);
      random_sent++;
   endtask

   // Picks the third byte of an E2 80 sequence: mostly a mapped one.
   function automatic logic [BYTE_W-1:0] pick_tail();
      case ($urandom_range(8))
         0: return CH_LDQUO;
         1: return CH_RDQUO;
         2: return CH_LSQUO;
         3: return CH_RSQUO;
         4: return CH_ENDASH;
         5: return CH_EMDASH;
         6, 7: return CH_ELLIPSIS;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // One random chunk: a printable run, a punctuation sequence, a broken
   // sequence, an escape, a tag with arbitrary content, or plain noise.
   task automatic send_chunk();
      int unsigned r;
      int unsigned n;
      r = $urandom_range(99);
      if (r < 30) begin
         n = $urandom_range(6, 1);
         repeat (n) put(8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO)));
      end else if (r < 55) begin
         put(CH_LEAD);
         put(CH_MID);
         put(pick_tail());
      end else if (r < 63) begin
         put(CH_LEAD);
         put(8'($urandom_range(255)));
         put(8'($urandom_range(255)));
      end else if (r < 73) begin
         put(CH_BSLASH);
         put(8'($urandom_range(255)));
      end else if (r < 85) begin
         put(CH_TAG_OPEN);
         n = $urandom_range(4);
         repeat (n) put(8'($urandom_range(255)));
         put(CH_TAG_SHUT);
      end else begin
         put(8'($urandom_range(255)));
      end
   endtask

   // Response side: check each accepted beat, then decide on ready for the
   // next cycle. Stalls are held with a countdown so each step has one update.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_response(rsp_bus.out_byte, rsp_bus.out_valid,
                              rsp_bus.out_line_end, rsp_bus.last_of_run);
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         hold_left = pick_gap();
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      random_sent        = 0;
      quiet              = 1'b0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.byte_value <= CH_NUL;
      req_bus.has_byte   <= 1'b0;
      req_bus.line_end   <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Each mapped punctuation family, the ellipsis at a line
      // end, an unknown second byte, an escaped lead byte, a tag that spans a
      // line, a tag opened right after a backslash, range extremes, a sequence
      // cut by a line end, and both kinds of items without a byte.
      send_beat(CH_LEAD, 1'b1, 1'b0);
      send_beat(CH_MID, 1'b1, 1'b0);
      send_beat(CH_LDQUO, 1'b1, 1'b0);
      send_beat(CH_LEAD, 1'b1, 1'b0);
      send_beat(CH_MID, 1'b1, 1'b0);
      send_beat(CH_RSQUO, 1'b1, 1'b0);
      send_beat(CH_LEAD, 1'b1, 1'b0);
      send_beat(CH_MID, 1'b1, 1'b0);
      send_beat(CH_EMDASH, 1'b1, 1'b0);
      send_beat(CH_LEAD, 1'b1, 1'b0);
      send_beat(CH_MID, 1'b1, 1'b0);
      send_beat(CH_ELLIPSIS, 1'b1, 1'b1);
      send_beat(CH_LEAD, 1'b1, 1'b0);
      send_beat(8'h81, 1'b1, 1'b0);
      send_beat(8'h41, 1'b1, 1'b0);
      send_beat(CH_BSLASH, 1'b1, 1'b0);
      send_beat(CH_LEAD, 1'b1, 1'b0);
      send_beat(CH_TAG_OPEN, 1'b1, 1'b0);
      send_beat(8'h71, 1'b1, 1'b1);
      send_beat(CH_TAG_SHUT, 1'b1, 1'b0);
      // The escape stays pending through the tag, so 'z' goes out raw.
      send_beat(CH_BSLASH, 1'b1, 1'b0);
      send_beat(CH_TAG_OPEN, 1'b1, 1'b0);
      send_beat(CH_TAG_SHUT, 1'b1, 1'b0);
      send_beat(8'h7A, 1'b1, 1'b0);
      send_beat(CH_NUL, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(CH_PRINT_LO, 1'b1, 1'b0);
      send_beat(CH_PRINT_HI, 1'b1, 1'b0);
      send_beat(CH_LEAD, 1'b1, 1'b1);
      send_beat(CH_MID, 1'b1, 1'b0);
      send_beat(8'hA5, 1'b0, 1'b0);
      send_beat(8'h5A, 1'b0, 1'b1);

      // Random part, with occasional stretches where neither side idles.
      while (random_sent < RANDOM_ITEMS) begin
         if ($urandom_range(19) == 0)
            quiet = ~quiet;
         send_chunk();
      end
      quiet = 1'b0;
      req_bus.valid <= 1'b0;

      // Let the response side drain, then give the unit a few more cycles to
      // show any beat it should not produce.
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
